// ----- hw/rtl/nns_pkg.sv -----
// shared constants, types and divider step for the nearest-neighbor source address generator
`default_nettype none

package nns_pkg;

    // fixed field widths
    localparam int NNS_REG_W   = 13;
    localparam int NNS_COORD_W = 12;
    localparam int NNS_INDEX_W = 26;
    localparam int NNS_PROD_W  = NNS_COORD_W + NNS_REG_W;
    localparam int NNS_ADDR_W  = 2;

    // divider shape: quotient bits, bits retired per stage, stage count
    localparam int NNS_QUOT_W          = 14;
    localparam int NNS_STEPS_PER_STAGE = 2;
    localparam int NNS_DIV_STAGES      = NNS_QUOT_W / NNS_STEPS_PER_STAGE;

    // start-to-strobe latency: capture, multiply, divider, index, output
    localparam int NNS_LATENCY = NNS_DIV_STAGES + 4;

    // defaults for the top-level parameters
    localparam int NNS_MAX_DIM_DEF    = 4096;
    localparam int NNS_COMPONENTS_DEF = 3;

    // register indexes
    localparam logic [NNS_ADDR_W-1:0] NNS_REG_SRC_WIDTH  = 2'd0;
    localparam logic [NNS_ADDR_W-1:0] NNS_REG_SRC_HEIGHT = 2'd1;
    localparam logic [NNS_ADDR_W-1:0] NNS_REG_DST_WIDTH  = 2'd2;
    localparam logic [NNS_ADDR_W-1:0] NNS_REG_DST_HEIGHT = 2'd3;

    typedef struct packed {
        logic [NNS_REG_W-1:0] src_w;
        logic [NNS_REG_W-1:0] src_h;
        logic [NNS_REG_W-1:0] dst_w;
        logic [NNS_REG_W-1:0] dst_h;
    } nns_dims_t;

    // one restoring division in flight
    typedef struct packed {
        logic [NNS_REG_W-1:0]  rem;
        logic [NNS_QUOT_W-1:0] low;
        logic [NNS_QUOT_W-1:0] quot;
    } nns_lane_t;

    typedef struct packed {
        logic      ok;
        nns_lane_t lx;
        nns_lane_t ly;
    } nns_div_word_t;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic nns_lane_t nns_div_step(nns_lane_t l, logic [NNS_REG_W-1:0] d);
        logic [NNS_REG_W:0] t;
        nns_lane_t          r;
        t      = {l.rem, l.low[NNS_QUOT_W-1]};
        r.low  = {l.low[NNS_QUOT_W-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            r.rem  = NNS_REG_W'(t - {1'b0, d});
            r.quot = {l.quot[NNS_QUOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t[NNS_REG_W-1:0];
            r.quot = {l.quot[NNS_QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nearest_neighbour_scaler_address.sv -----
// top level of the nearest-neighbor source address generator
//
//  channel   signals                                   direction  transfer
//  command   start, busy, dst_x, dst_y                 in         start && !busy
//  result    done, src_x, src_y, src_index, coord_ok   out        done (one cycle)
//  config    cfg_we, cfg_addr, cfg_wdata               in         cfg_we
//
// one command word per clock; busy is always low since nothing can hold the pipe
// result strobe follows the command edge through these registers, in order:
//   capture, multiply, 7 divider stages of 2 quotient bits each, index multiply, output
// latency is set by the divider chain, one quotient bit pair per stage;
// throughput is one word per cycle
// reset clears all valid bits and loads every size register with 1
// the result side takes every word, so no stall paths exist
`default_nettype none

module nearest_neighbour_scaler_address #(
    parameter int MAX_DIM    = nns_pkg::NNS_MAX_DIM_DEF,
    parameter int COMPONENTS = nns_pkg::NNS_COMPONENTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // command
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [nns_pkg::NNS_COORD_W-1:0]  dst_x,
    input  wire logic [nns_pkg::NNS_COORD_W-1:0]  dst_y,
    // result
    output logic                                  done,
    output logic [nns_pkg::NNS_COORD_W-1:0]       src_x,
    output logic [nns_pkg::NNS_COORD_W-1:0]       src_y,
    output logic [nns_pkg::NNS_INDEX_W-1:0]       src_index,
    output logic                                  coord_ok,
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [nns_pkg::NNS_ADDR_W-1:0]   cfg_addr,
    input  wire logic [nns_pkg::NNS_REG_W-1:0]    cfg_wdata
);
    import nns_pkg::*;

    // raw size registers, as written
    logic [NNS_REG_W-1:0] src_w_reg;
    logic [NNS_REG_W-1:0] src_h_reg;
    logic [NNS_REG_W-1:0] dst_w_reg;
    logic [NNS_REG_W-1:0] dst_h_reg;

    // MAX_DIM-capped sizes; user keeps them stable while words are in flight, unguarded
    nns_dims_t dims;

    logic          accept;
    logic          stage_valid [NNS_DIV_STAGES+1];
    nns_div_word_t stage_word  [NNS_DIV_STAGES+1];

    function automatic logic [NNS_REG_W-1:0] clamp_dim(logic [NNS_REG_W-1:0] v);
        if (32'(v) > 32'(MAX_DIM))
            return NNS_REG_W'(MAX_DIM);
        else
            return v;
    endfunction

    // configuration writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= NNS_REG_W'(1);
            src_h_reg <= NNS_REG_W'(1);
            dst_w_reg <= NNS_REG_W'(1);
            dst_h_reg <= NNS_REG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                NNS_REG_SRC_WIDTH:  src_w_reg <= cfg_wdata;
                NNS_REG_SRC_HEIGHT: src_h_reg <= cfg_wdata;
                NNS_REG_DST_WIDTH:  dst_w_reg <= cfg_wdata;
                NNS_REG_DST_HEIGHT: dst_h_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        dims.src_w = clamp_dim(src_w_reg);
        dims.src_h = clamp_dim(src_h_reg);
        dims.dst_w = clamp_dim(dst_w_reg);
        dims.dst_h = clamp_dim(dst_h_reg);
    end

    // fully pipelined, so a new command is taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // capture and products x*src_w, y*src_h
    nns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .dims      (dims),
        .out_valid (stage_valid[0]),
        .out_word  (stage_word[0])
    );

    // restoring dividers for column and row, two quotient bits per stage
    for (genvar s = 0; s < NNS_DIV_STAGES; s++)
    begin : g_div
        nns_div_stage #(
            .STEPS (NNS_STEPS_PER_STAGE)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[s]),
            .in_word   (stage_word[s]),
            .dims      (dims),
            .out_valid (stage_valid[s+1]),
            .out_word  (stage_word[s+1])
        );
    end

    // buffer index and output register
    nns_index #(
        .COMPONENTS (COMPONENTS)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NNS_DIV_STAGES]),
        .in_word   (stage_word[NNS_DIV_STAGES]),
        .src_w     (dims.src_w),
        .done      (done),
        .src_x     (src_x),
        .src_y     (src_y),
        .src_index (src_index),
        .coord_ok  (coord_ok)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/nns_front.sv -----
// front end: coordinate capture, range check and products that feed the dividers
`default_nettype none

module nns_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [nns_pkg::NNS_COORD_W-1:0] dst_x,
    input  wire logic [nns_pkg::NNS_COORD_W-1:0] dst_y,
    input  wire nns_pkg::nns_dims_t            dims,
    output logic                               out_valid,
    output nns_pkg::nns_div_word_t             out_word
);
    import nns_pkg::*;

    logic                   cap_valid_reg;
    logic [NNS_COORD_W-1:0] x_reg;
    logic [NNS_COORD_W-1:0] y_reg;
    logic                   ok_reg;
    logic                   ok_next;

    logic                   mul_valid_reg;
    nns_div_word_t          word_reg;
    nns_div_word_t          word_next;
    logic [NNS_PROD_W-1:0]  px;
    logic [NNS_PROD_W-1:0]  py;

    // inside the destination and a nonempty source
    assign ok_next = ({1'b0, dst_x} < dims.dst_w) && ({1'b0, dst_y} < dims.dst_h)
                     && (dims.src_w != '0) && (dims.src_h != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            cap_valid_reg <= in_valid;
            mul_valid_reg <= cap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= dst_x;
        y_reg    <= dst_y;
        ok_reg   <= ok_next;
        word_reg <= word_next;
    end

    // dividend top bits start as the partial remainder, the rest shift in
    always_comb
    begin
        px                = NNS_PROD_W'(x_reg) * NNS_PROD_W'(dims.src_w);
        py                = NNS_PROD_W'(y_reg) * NNS_PROD_W'(dims.src_h);
        word_next.ok      = ok_reg;
        word_next.lx.rem  = NNS_REG_W'(px >> NNS_QUOT_W);
        word_next.lx.low  = px[NNS_QUOT_W-1:0];
        word_next.lx.quot = '0;
        word_next.ly.rem  = NNS_REG_W'(py >> NNS_QUOT_W);
        word_next.ly.low  = py[NNS_QUOT_W-1:0];
        word_next.ly.quot = '0;
    end

    assign out_valid = mul_valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nns_div_stage.sv -----
// one divider stage: STEPS restoring steps on both coordinate lanes
`default_nettype none

module nns_div_stage #(
    parameter int STEPS = nns_pkg::NNS_STEPS_PER_STAGE
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire nns_pkg::nns_div_word_t        in_word,
    input  wire nns_pkg::nns_dims_t            dims,
    output logic                               out_valid,
    output nns_pkg::nns_div_word_t             out_word
);
    import nns_pkg::*;

    logic          valid_reg;
    nns_div_word_t word_reg;
    nns_div_word_t word_next;

    always_comb
    begin
        word_next = in_word;
        for (int i = 0; i < STEPS; i++)
        begin
            word_next.lx = nns_div_step(word_next.lx, dims.dst_w);
            word_next.ly = nns_div_step(word_next.ly, dims.dst_h);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nns_index.sv -----
// back end: buffer index multiply and the output register
`default_nettype none

module nns_index #(
    parameter int COMPONENTS = nns_pkg::NNS_COMPONENTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire nns_pkg::nns_div_word_t          in_word,
    input  wire logic [nns_pkg::NNS_REG_W-1:0]   src_w,
    output logic                                 done,
    output logic [nns_pkg::NNS_COORD_W-1:0]      src_x,
    output logic [nns_pkg::NNS_COORD_W-1:0]      src_y,
    output logic [nns_pkg::NNS_INDEX_W-1:0]      src_index,
    output logic                                 coord_ok
);
    import nns_pkg::*;

    logic                   a_valid_reg;
    logic                   a_ok_reg;
    logic [NNS_COORD_W-1:0] a_col_reg;
    logic [NNS_COORD_W-1:0] a_row_reg;
    logic [NNS_INDEX_W-1:0] a_base_reg;
    logic [NNS_INDEX_W-1:0] a_base_next;

    logic                   done_reg;
    logic                   ok_reg;
    logic [NNS_COORD_W-1:0] x_reg;
    logic [NNS_COORD_W-1:0] y_reg;
    logic [NNS_INDEX_W-1:0] index_reg;
    logic [NNS_INDEX_W-1:0] index_next;

    // pixel number row*src_w + col, kept modulo the index width
    assign a_base_next = NNS_INDEX_W'(in_word.ly.quot[NNS_REG_W-1:0]) * NNS_INDEX_W'(src_w)
                       + NNS_INDEX_W'(in_word.lx.quot[NNS_REG_W-1:0]);

    assign index_next = NNS_INDEX_W'(a_base_reg * NNS_INDEX_W'(COMPONENTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
            ok_reg      <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            done_reg    <= a_valid_reg;
            ok_reg      <= a_valid_reg && a_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ok_reg   <= in_word.ok;
        a_col_reg  <= in_word.lx.quot[NNS_COORD_W-1:0];
        a_row_reg  <= in_word.ly.quot[NNS_COORD_W-1:0];
        a_base_reg <= a_base_next;
        // fields read zero when the coordinate is rejected
        x_reg      <= a_ok_reg ? a_col_reg  : '0;
        y_reg      <= a_ok_reg ? a_row_reg  : '0;
        index_reg  <= a_ok_reg ? index_next : '0;
    end

    assign done      = done_reg;
    assign coord_ok  = ok_reg;
    assign src_x     = x_reg;
    assign src_y     = y_reg;
    assign src_index = index_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/nns_checker.sv -----
// port-level checks for the nearest-neighbor source address generator, with bind
`default_nettype none

module nns_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             done,
    input wire logic [nns_pkg::NNS_COORD_W-1:0]  src_x,
    input wire logic [nns_pkg::NNS_COORD_W-1:0]  src_y,
    input wire logic [nns_pkg::NNS_INDEX_W-1:0]  src_index,
    input wire logic                             coord_ok
);
    import nns_pkg::*;

    // every accepted command gives a result strobe
    a_cmd_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##NNS_LATENCY done)
        else $error("accepted command produced no result word");

    // no strobe without a matching accepted command
    a_no_extra_done : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, NNS_LATENCY))
        else $error("result word without a matching command");

    // coord_ok only rides on a strobe
    a_ok_with_done : assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !coord_ok)
        else $error("coord_ok high outside a result word");

    // rejected coordinates give zero fields
    a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !coord_ok) |-> (src_x == '0 && src_y == '0 && src_index == '0))
        else $error("rejected coordinate with nonzero fields");

endmodule

bind nearest_neighbour_scaler_address nns_checker u_nns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .src_x     (src_x),
    .src_y     (src_y),
    .src_index (src_index),
    .coord_ok  (coord_ok)
);

`default_nettype wire
